@@ rtl/core/avr_pkg.sv @@
// ----------------------------------------------------------------------------
// avr_pkg
// Shared types, constants and the arctangent table for the angle/vector
// rotation core.
// ----------------------------------------------------------------------------
package avr_pkg;

  // number of micro-rotations requested and the size of the arctangent table
  localparam int ROTATION_STEPS = 18;
  localparam int ATAN_ENTRIES   = 24;
  localparam int CORDIC_STEPS   = (ROTATION_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                  : ROTATION_STEPS;

  // datapath widths
  localparam int DATA_W    = 16;                  // vector components and results
  localparam int CORDIC_W  = 32;                  // cos, sin and residual angle
  localparam int FRAC_BITS = 30;                  // fraction bits of cos and sin
  localparam int PROD_W    = CORDIC_W + DATA_W;   // one product
  localparam int ACC_W     = PROD_W + 2;          // doubled sum of two products
  localparam int RND_W     = ACC_W - FRAC_BITS + 1;
  localparam int ATAN_IDX_W = $clog2(ATAN_ENTRIES);

  // reciprocal of the CORDIC gain at its limit, 30 fraction bits
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // 16-bit saturation limits at rounded width
  localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'(32767);
  localparam logic signed [RND_W-1:0] SAT_MIN = -RND_W'(32768);

  // quadrant taken from angle bits 15:14
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // rotated basis and vector handed from the rotation pipe to the mixer
  typedef struct packed {
    logic signed [CORDIC_W-1:0] c;
    logic signed [CORDIC_W-1:0] s;
    logic signed [DATA_W-1:0]   x;
    logic signed [DATA_W-1:0]   y;
  } rot_t;

  // atan(2^-i), 2^32 units per turn, truncated
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [CORDIC_W-1:0] v;
    case (idx)
      5'd0:    v = 32'sd536870912;
      5'd1:    v = 32'sd316933405;
      5'd2:    v = 32'sd167458907;
      5'd3:    v = 32'sd85004756;
      5'd4:    v = 32'sd42667331;
      5'd5:    v = 32'sd21354465;
      5'd6:    v = 32'sd10679838;
      5'd7:    v = 32'sd5340245;
      5'd8:    v = 32'sd2670163;
      5'd9:    v = 32'sd1335086;
      5'd10:   v = 32'sd667544;
      5'd11:   v = 32'sd333772;
      5'd12:   v = 32'sd166886;
      5'd13:   v = 32'sd83443;
      5'd14:   v = 32'sd41721;
      5'd15:   v = 32'sd20860;
      5'd16:   v = 32'sd10430;
      5'd17:   v = 32'sd5215;
      5'd18:   v = 32'sd2607;
      5'd19:   v = 32'sd1303;
      5'd20:   v = 32'sd651;
      5'd21:   v = 32'sd325;
      5'd22:   v = 32'sd162;
      5'd23:   v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/avr_cordic.sv @@
// ----------------------------------------------------------------------------
// avr_cordic
// Unrolled CORDIC rotation, one micro-rotation per register stage, followed
// by a stage that maps the first-quadrant result to the input's quadrant.
// ----------------------------------------------------------------------------
module avr_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [avr_pkg::DATA_W-1:0] angle,
  input  logic signed [avr_pkg::DATA_W-1:0] y_in,
  input  logic signed [avr_pkg::DATA_W-1:0] x_in,
  output logic                              rot_valid,
  input  logic                              rot_ready,
  output avr_pkg::rot_t                     rot
);

  // stage valids: iterations 0..CORDIC_STEPS-1, then the quadrant stage
  logic [avr_pkg::CORDIC_STEPS:0] vld;
  logic [avr_pkg::CORDIC_STEPS:0] rdy;
  logic [avr_pkg::CORDIC_STEPS:0] vsrc;

  // per-iteration payload
  logic signed [avr_pkg::CORDIC_W-1:0] cx_r      [avr_pkg::CORDIC_STEPS];
  logic signed [avr_pkg::CORDIC_W-1:0] sy_r      [avr_pkg::CORDIC_STEPS];
  logic signed [avr_pkg::CORDIC_W-1:0] z_r       [avr_pkg::CORDIC_STEPS];
  logic [1:0]                          quad_r    [avr_pkg::CORDIC_STEPS];
  logic signed [avr_pkg::DATA_W-1:0]   x_r       [avr_pkg::CORDIC_STEPS];
  logic signed [avr_pkg::DATA_W-1:0]   y_r       [avr_pkg::CORDIC_STEPS];
  logic signed [avr_pkg::CORDIC_W-1:0] cx_next   [avr_pkg::CORDIC_STEPS];
  logic signed [avr_pkg::CORDIC_W-1:0] sy_next   [avr_pkg::CORDIC_STEPS];
  logic signed [avr_pkg::CORDIC_W-1:0] z_next    [avr_pkg::CORDIC_STEPS];
  logic [1:0]                          quad_next [avr_pkg::CORDIC_STEPS];
  logic signed [avr_pkg::DATA_W-1:0]   x_next    [avr_pkg::CORDIC_STEPS];
  logic signed [avr_pkg::DATA_W-1:0]   y_next    [avr_pkg::CORDIC_STEPS];

  avr_pkg::rot_t rot_r;
  avr_pkg::rot_t rot_next;

  // a stage may load when the output is taken or when it or any stage after it is empty
  always_comb begin
    logic [avr_pkg::CORDIC_STEPS:0] low_mask;
    for (int j = 0; j <= avr_pkg::CORDIC_STEPS; j++) begin
      low_mask = (avr_pkg::CORDIC_STEPS+1)'((64'd1 << j) - 64'd1);
      rdy[j]   = rot_ready || !(&(vld | low_mask));
      vsrc[j]  = (j == 0) ? in_valid : vld[j-1];
    end
  end

  assign in_ready = rdy[0];

  // micro-rotations, each fed by the previous stage
  always_comb begin
    logic signed [avr_pkg::CORDIC_W-1:0] cx_s;
    logic signed [avr_pkg::CORDIC_W-1:0] sy_s;
    logic signed [avr_pkg::CORDIC_W-1:0] z_s;
    logic signed [avr_pkg::CORDIC_W-1:0] dx;
    logic signed [avr_pkg::CORDIC_W-1:0] dy;
    logic signed [avr_pkg::CORDIC_W-1:0] at;
    for (int j = 0; j < avr_pkg::CORDIC_STEPS; j++) begin
      if (j == 0) begin
        cx_s         = avr_pkg::CORDIC_GAIN;
        sy_s         = '0;
        z_s          = {2'b00, angle[13:0], 16'h0000};
        quad_next[j] = angle[15:14];
        x_next[j]    = x_in;
        y_next[j]    = y_in;
      end else begin
        cx_s         = cx_r[j-1];
        sy_s         = sy_r[j-1];
        z_s          = z_r[j-1];
        quad_next[j] = quad_r[j-1];
        x_next[j]    = x_r[j-1];
        y_next[j]    = y_r[j-1];
      end
      dx = sy_s >>> j;
      dy = cx_s >>> j;
      at = avr_pkg::atan_turn(avr_pkg::ATAN_IDX_W'(j));
      if (!z_s[avr_pkg::CORDIC_W-1]) begin
        cx_next[j] = cx_s - dx;
        sy_next[j] = sy_s + dy;
        z_next[j]  = z_s - at;
      end else begin
        cx_next[j] = cx_s + dx;
        sy_next[j] = sy_s - dy;
        z_next[j]  = z_s + at;
      end
    end
  end

  // quadrant mapping by swap and negate
  always_comb begin
    logic signed [avr_pkg::CORDIC_W-1:0] cx_l;
    logic signed [avr_pkg::CORDIC_W-1:0] sy_l;
    cx_l       = cx_r[avr_pkg::CORDIC_STEPS-1];
    sy_l       = sy_r[avr_pkg::CORDIC_STEPS-1];
    rot_next.x = x_r[avr_pkg::CORDIC_STEPS-1];
    rot_next.y = y_r[avr_pkg::CORDIC_STEPS-1];
    case (avr_pkg::quad_t'(quad_r[avr_pkg::CORDIC_STEPS-1]))
      avr_pkg::QUAD_1: begin
        rot_next.c = -sy_l;
        rot_next.s = cx_l;
      end
      avr_pkg::QUAD_2: begin
        rot_next.c = -cx_l;
        rot_next.s = -sy_l;
      end
      avr_pkg::QUAD_3: begin
        rot_next.c = sy_l;
        rot_next.s = -cx_l;
      end
      default: begin
        rot_next.c = cx_l;
        rot_next.s = sy_l;
      end
    endcase
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int j = 0; j <= avr_pkg::CORDIC_STEPS; j++) begin
        if (rdy[j]) begin
          vld[j] <= vsrc[j];
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    for (int j = 0; j < avr_pkg::CORDIC_STEPS; j++) begin
      if (rdy[j]) begin
        cx_r[j]   <= cx_next[j];
        sy_r[j]   <= sy_next[j];
        z_r[j]    <= z_next[j];
        quad_r[j] <= quad_next[j];
        x_r[j]    <= x_next[j];
        y_r[j]    <= y_next[j];
      end
    end
    if (rdy[avr_pkg::CORDIC_STEPS]) begin
      rot_r <= rot_next;
    end
  end

  assign rot_valid = vld[avr_pkg::CORDIC_STEPS];
  assign rot       = rot_r;

endmodule

@@ rtl/core/avr_mix.sv @@
// ----------------------------------------------------------------------------
// avr_mix
// Combines the rotated basis with the vector: four products, doubled sums,
// round half to even, then clamp to 16 bits. Four register stages.
// ----------------------------------------------------------------------------
module avr_mix (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rot_valid,
  output logic                              rot_ready,
  input  avr_pkg::rot_t                     rot,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [avr_pkg::DATA_W-1:0] sum_out,
  output logic signed [avr_pkg::DATA_W-1:0] diff_out,
  output logic                              saturated
);

  // round a value with FRAC_BITS fraction bits to nearest, ties to even
  function automatic logic signed [avr_pkg::RND_W-1:0] round_even(
    input logic signed [avr_pkg::ACC_W-1:0] v
  );
    logic signed [avr_pkg::RND_W-1:0] q;
    logic [avr_pkg::FRAC_BITS-1:0]    rem;
    logic                             up;
    q   = avr_pkg::RND_W'(v >>> avr_pkg::FRAC_BITS);
    rem = v[avr_pkg::FRAC_BITS-1:0];
    up  = rem[avr_pkg::FRAC_BITS-1] &&
          ((rem[avr_pkg::FRAC_BITS-2:0] != '0) || q[0]);
    return q + avr_pkg::RND_W'(up);
  endfunction

  logic vld1, vld2, vld3, vld4;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: products
  logic signed [avr_pkg::PROD_W-1:0] sx_p, cy_p, cx_p, sy_p;
  // stage 2: doubled sum and difference
  logic signed [avr_pkg::ACC_W-1:0]  sum_a, diff_a;
  logic signed [avr_pkg::ACC_W-1:0]  sum_a_next, diff_a_next;
  // stage 3: rounded values
  logic signed [avr_pkg::RND_W-1:0]  sum_q, diff_q;
  // stage 4: clamped outputs
  logic signed [avr_pkg::DATA_W-1:0] sum_next, diff_next;
  logic                              sat_next;

  // per-stage ready
  assign rdy4      = !vld4 || out_ready;
  assign rdy3      = !vld3 || rdy4;
  assign rdy2      = !vld2 || rdy3;
  assign rdy1      = !vld1 || rdy2;
  assign rot_ready = rdy1;

  // doubled sums
  always_comb begin
    sum_a_next  = (avr_pkg::ACC_W'(sx_p) + avr_pkg::ACC_W'(cy_p)) <<< 1;
    diff_a_next = (avr_pkg::ACC_W'(cx_p) - avr_pkg::ACC_W'(sy_p)) <<< 1;
  end

  // clamp to 16 bits
  always_comb begin
    sat_next = 1'b0;
    if (sum_q > avr_pkg::SAT_MAX) begin
      sum_next = avr_pkg::DATA_W'(avr_pkg::SAT_MAX);
      sat_next = 1'b1;
    end else if (sum_q < avr_pkg::SAT_MIN) begin
      sum_next = avr_pkg::DATA_W'(avr_pkg::SAT_MIN);
      sat_next = 1'b1;
    end else begin
      sum_next = avr_pkg::DATA_W'(sum_q);
    end
    if (diff_q > avr_pkg::SAT_MAX) begin
      diff_next = avr_pkg::DATA_W'(avr_pkg::SAT_MAX);
      sat_next  = 1'b1;
    end else if (diff_q < avr_pkg::SAT_MIN) begin
      diff_next = avr_pkg::DATA_W'(avr_pkg::SAT_MIN);
      sat_next  = 1'b1;
    end else begin
      diff_next = avr_pkg::DATA_W'(diff_q);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else begin
      if (rdy1) vld1 <= rot_valid;
      if (rdy2) vld2 <= vld1;
      if (rdy3) vld3 <= vld2;
      if (rdy4) vld4 <= vld3;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (rdy1) begin
      sx_p <= rot.s * rot.x;
      cy_p <= rot.c * rot.y;
      cx_p <= rot.c * rot.x;
      sy_p <= rot.s * rot.y;
    end
    if (rdy2) begin
      sum_a  <= sum_a_next;
      diff_a <= diff_a_next;
    end
    if (rdy3) begin
      sum_q  <= round_even(sum_a);
      diff_q <= round_even(diff_a);
    end
    if (rdy4) begin
      sum_out   <= sum_next;
      diff_out  <= diff_next;
      saturated <= sat_next;
    end
  end

  assign out_valid = vld4;

endmodule

@@ rtl/core/angle_vector_rotation_core.sv @@
// ----------------------------------------------------------------------------
// angle_vector_rotation_core
// Rotates a signed 16-bit vector by a 16-bit angle (65536 units per turn):
// sum = 2*(sin*x + cos*y), diff = 2*(cos*x - sin*y), rounded half to even
// and saturated to 16 bits.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   angle, y_in, x_in
//   output   out_valid / out_ready sum_out, diff_out, saturated
//
// One request per cycle while the output is accepted; the pipeline holds one
// micro-rotation per stage, then the quadrant, multiply, add, round and
// clamp stages.
// Every stage carries its own valid bit; a stalled output holds only the
// stages that are full, so requests keep entering into empty slots.
// Synchronous reset clears the valid bits only; no state is kept per request.
// ----------------------------------------------------------------------------
module angle_vector_rotation_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [avr_pkg::DATA_W-1:0] angle,
  input  logic signed [avr_pkg::DATA_W-1:0] y_in,
  input  logic signed [avr_pkg::DATA_W-1:0] x_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [avr_pkg::DATA_W-1:0] sum_out,
  output logic signed [avr_pkg::DATA_W-1:0] diff_out,
  output logic                              saturated
);

  logic          rot_valid;
  logic          rot_ready;
  avr_pkg::rot_t rot;

  // cosine and sine of the angle, vector carried alongside
  avr_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .angle     (angle),
    .y_in      (y_in),
    .x_in      (x_in),
    .rot_valid (rot_valid),
    .rot_ready (rot_ready),
    .rot       (rot)
  );

  // products, rounding and saturation
  avr_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .rot_valid (rot_valid),
    .rot_ready (rot_ready),
    .rot       (rot),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sum_out   (sum_out),
    .diff_out  (diff_out),
    .saturated (saturated)
  );

endmodule
